>>> hdl/ipr_pkg.sv
// Shared types and constants for the IPv4 range table lookup block.
// Used by ipr_front, ipr_queue, ipr_back and ip_range_table_lookup.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

   localparam int unsigned IPR_TABLE_DEPTH = 16384;

   // Codes on the request type field.
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // Codes on the result status field.
   typedef enum logic [1:0] {
      ST_LOADED  = 2'd0,
      ST_FULL    = 2'd1,
      ST_MATCH   = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] entry_start;
      logic [31:0] entry_end;
      logic [15:0] entry_country;
      logic [31:0] query_addr;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] country_code;
   } rsp_type;

   // Classified command handed from the front end to the execution side.
   typedef struct packed {
      op_type      op;
      logic [31:0] range_start;
      logic [31:0] range_last;
      logic [15:0] country;
      logic [31:0] key;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_CHECK,
      BK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

>>> hdl/ipr_front.sv
// Front end of the range table lookup: input register that takes request
// beats and classifies them into load or lookup commands. Uses ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_front
   import ipr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              push_valid,
   input  wire logic         push_ready,
   output cmd_type           push_data
);

   logic    front_valid_ff;
   logic    front_valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   assign req_stall  = front_valid_ff && !push_ready;
   assign take       = req_valid && !req_stall;
   assign push_valid = front_valid_ff;
   assign push_data  = cmd_ff;

   always_comb begin
      cmd_in = cmd_ff;
      if (take) begin
         cmd_in.op          = req_data.req_type ? OP_LOOKUP : OP_LOAD;
         cmd_in.range_start = req_data.entry_start;
         cmd_in.range_last  = req_data.entry_end;
         cmd_in.country     = req_data.entry_country;
         cmd_in.key         = req_data.query_addr;
      end
   end

   always_comb begin
      if (take) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

>>> hdl/ipr_queue.sv
// Two-entry command queue between the front end and the search engine.
// Uses cmd_type from ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_queue
   import ipr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_data,
   output logic         pop_valid,
   input  wire logic    pop,
   output cmd_type      pop_data
);

   cmd_type    slots_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] level_ff;
   logic [1:0] level_in;
   logic       do_push;

   assign push_ready = (level_ff != 2'd2);
   assign pop_valid  = (level_ff != 2'd0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;

   always_comb begin
      level_in = level_ff;
      if (do_push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (!do_push && pop) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         level_ff <= level_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ipr_back.sv
// Execution side: range table memories, entry counter, binary search
// sequencer and result register. Uses ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_back
   import ipr_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = IPR_TABLE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   logic [31:0] starts_mem    [TABLE_DEPTH];
   logic [31:0] ends_mem      [TABLE_DEPTH];
   logic [15:0] countries_mem [TABLE_DEPTH];

   logic [31:0] start_rd_ff;
   logic [31:0] end_rd_ff;
   logic [15:0] country_rd_ff;
   logic [IDX_W-1:0] rd_idx;
   logic             mem_we;

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [31:0]      addr_ff, addr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic [CNT_W-1:0] lo_n;
   logic [CNT_W-1:0] hi_n;
   logic [CNT_W-1:0] mid_n;
   logic [CNT_W-1:0] cand;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One halving step: the start entry at mid was read in the previous cycle.
   always_comb begin
      if (start_rd_ff <= addr_ff) begin
         lo_n = mid_ff + CNT_W'(1);
         hi_n = hi_ff;
      end else begin
         lo_n = lo_ff;
         hi_n = mid_ff;
      end
      mid_n = lo_n + ((hi_n - lo_n) >> 1);
      cand  = lo_n - CNT_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rd_idx       = mid_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_data.op == OP_LOAD) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.country_code = 16'd0;
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_data_in.status = ST_FULL;
                  end else begin
                     mem_we             = 1'b1;
                     count_in           = count_ff + CNT_W'(1);
                     rsp_data_in.status = ST_LOADED;
                  end
               end else begin
                  addr_in = q_data.key;
                  if (count_ff == '0) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.status       = ST_NOMATCH;
                     rsp_data_in.country_code = 16'd0;
                  end else begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     mid_in   = count_ff >> 1;
                     rd_idx   = mid_in[IDX_W-1:0];
                     state_in = BK_SEARCH;
                  end
               end
            end
         end
         BK_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_in = mid_n;
               rd_idx = mid_n[IDX_W-1:0];
            end else if (lo_n == '0) begin
               res_in.status       = ST_NOMATCH;
               res_in.country_code = 16'd0;
               state_in            = BK_FINISH;
            end else begin
               rd_idx   = cand[IDX_W-1:0];
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (addr_ff <= end_rd_ff) begin
               res_in.status       = ST_MATCH;
               res_in.country_code = country_rd_ff;
            end else begin
               res_in.status       = ST_NOMATCH;
               res_in.country_code = 16'd0;
            end
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table memories: one write port at the fill position, one registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         starts_mem[count_ff[IDX_W-1:0]] <= q_data.range_start;
      end
      start_rd_ff <= starts_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ends_mem[count_ff[IDX_W-1:0]] <= q_data.range_last;
      end
      end_rd_ff <= ends_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         countries_mem[count_ff[IDX_W-1:0]] <= q_data.country;
      end
      country_rd_ff <= countries_mem[rd_idx];
   end

endmodule

`default_nettype wire

>>> hdl/ip_range_table_lookup.sv
// IPv4 range table with binary-search lookup: top level wiring of front end,
// command queue and search engine. Uses ipr_pkg, ipr_front, ipr_queue, ipr_back.
//
// Load beats append one range (first address, last address, country code) to
// the table in arrival order; a load into a full table is dropped and answered
// with the full status. Lookup beats return the code of the last loaded range
// whose first address is at most the query, if the query is also at most its
// last address (both bounds inclusive), else no match. Ranges should be loaded
// sorted by first address. Every request gives exactly one response beat, in
// order. A load is answered from the idle state without a search. A lookup
// runs halving steps over the loaded entries, one per cycle because each step
// needs the start address read from memory in the step before, then checks
// the candidate's last address and hands the result to the response register.
// A two-entry queue lets new requests come in while a search runs. Reset
// empties the table; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ip_range_table_lookup
   import ipr_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = IPR_TABLE_DEPTH
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_data;

   ipr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ipr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   ipr_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // The search engine only takes commands that the queue holds.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("command popped from an empty queue");

   // A command pushed into the queue is visible to the engine next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |=> q_valid)
      else $error("queue lost a pushed command");

   // Only a match carries a country code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_LOADED || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_NOMATCH)) |-> (rsp_data.country_code == 16'd0))
      else $error("nonzero country code on a non-match response");
`endif

endmodule

`default_nettype wire
